### src/tlex_pkg.sv
// Package for the term text lexer: state encoding, token kinds, character codes
// and the result and bundle types shared by the front end, queue and back end.
// No dependencies.
package tlex_pkg;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_VAR     = 4'd1,
		M_ATOM    = 4'd2,
		M_QATOM   = 4'd3,
		M_INT     = 4'd4,
		M_DOTWAIT = 4'd5,
		M_FRAC    = 4'd6,
		M_STR     = 4'd7,
		M_STRESC  = 4'd8
	} mode_t;

	localparam logic [3:0] TK_COMMA  = 4'd0;
	localparam logic [3:0] TK_DOT    = 4'd1;
	localparam logic [3:0] TK_LPAR   = 4'd2;
	localparam logic [3:0] TK_RPAR   = 4'd3;
	localparam logic [3:0] TK_LBRK   = 4'd4;
	localparam logic [3:0] TK_RBRK   = 4'd5;
	localparam logic [3:0] TK_LBRC   = 4'd6;
	localparam logic [3:0] TK_RBRC   = 4'd7;
	localparam logic [3:0] TK_VAR    = 4'd8;
	localparam logic [3:0] TK_ATOM   = 4'd9;
	localparam logic [3:0] TK_NUM    = 4'd10;
	localparam logic [3:0] TK_STR    = 4'd11;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LBRC   = 8'h7B;
	localparam logic [7:0] CH_RBRC   = 8'h7D;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [3:0] token_kind;
		logic       has_char;
		logic [7:0] char_out;
		logic       token_end;
	} res_t;

	typedef struct packed {
		logic [1:0]           count;
		res_t [MAX_RES-1:0]   res;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t bundle;
	} qwr_t;

	function automatic res_t mk_res(logic [3:0] k, logic has, logic [7:0] ch, logic fin);
		res_t r;
		r.token_kind = k;
		r.has_char   = has;
		r.char_out   = has ? ch : CH_NUL;
		r.token_end  = fin;
		return r;
	endfunction

	function automatic bundle_t add_res(bundle_t b, res_t r);
		bundle_t o;
		o = b;
		o.res[b.count] = r;
		o.count = b.count + 2'd1;
		return o;
	endfunction

endpackage

### src/tlex_front.sv
// Front end of the term text lexer: accepts text bytes, runs the lexer state
// machine and hands up to three results per byte to the queue as one bundle.
// Depends on tlex_pkg.
module tlex_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               kind,
	input  logic [7:0]         char_code,
	input  logic               q_full,
	output logic               byte_stall,
	output tlex_pkg::qwr_t     qwr
);

	tlex_pkg::mode_t   mode_q;
	tlex_pkg::mode_t   mode_d;
	tlex_pkg::mode_t   st_mode;
	tlex_pkg::res_t    st_res;
	tlex_pkg::bundle_t b;
	logic              st_has;
	logic              acc;
	logic              flush;
	logic              dig;
	logic              up;
	logic              lo;
	logic              word;

	assign byte_stall = q_full;
	assign acc        = byte_valid && !byte_stall;
	assign flush      = kind || (char_code == tlex_pkg::CH_NUL);
	assign dig        = char_code inside {[8'h30:8'h39]};
	assign up         = char_code inside {[8'h41:8'h5A]};
	assign lo         = char_code inside {[8'h61:8'h7A]};
	assign word       = dig || up || lo || (char_code == tlex_pkg::CH_USCORE);

	always_comb begin
		st_has  = 1'b1;
		st_mode = tlex_pkg::M_IDLE;
		st_res  = tlex_pkg::mk_res(tlex_pkg::TK_COMMA, 1'b0, tlex_pkg::CH_NUL, 1'b1);
		case (char_code)
			tlex_pkg::CH_COMMA: st_res.token_kind = tlex_pkg::TK_COMMA;
			tlex_pkg::CH_DOT:   st_res.token_kind = tlex_pkg::TK_DOT;
			tlex_pkg::CH_LPAR:  st_res.token_kind = tlex_pkg::TK_LPAR;
			tlex_pkg::CH_RPAR:  st_res.token_kind = tlex_pkg::TK_RPAR;
			tlex_pkg::CH_LBRK:  st_res.token_kind = tlex_pkg::TK_LBRK;
			tlex_pkg::CH_RBRK:  st_res.token_kind = tlex_pkg::TK_RBRK;
			tlex_pkg::CH_LBRC:  st_res.token_kind = tlex_pkg::TK_LBRC;
			tlex_pkg::CH_RBRC:  st_res.token_kind = tlex_pkg::TK_RBRC;
			tlex_pkg::CH_APOS: begin
				st_has  = 1'b0;
				st_mode = tlex_pkg::M_QATOM;
			end
			tlex_pkg::CH_DQUOTE: begin
				st_has  = 1'b0;
				st_mode = tlex_pkg::M_STR;
			end
			default: begin
				if (dig) begin
					st_res  = tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b1, char_code, 1'b0);
					st_mode = tlex_pkg::M_INT;
				end else if (up) begin
					st_res  = tlex_pkg::mk_res(tlex_pkg::TK_VAR, 1'b1, char_code, 1'b0);
					st_mode = tlex_pkg::M_VAR;
				end else if (lo) begin
					st_res  = tlex_pkg::mk_res(tlex_pkg::TK_ATOM, 1'b1, char_code, 1'b0);
					st_mode = tlex_pkg::M_ATOM;
				end else begin
					st_has = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		if (acc) begin
			if (flush) begin
				mode_d = tlex_pkg::M_IDLE;
			end else begin
				case (mode_q)
					tlex_pkg::M_VAR, tlex_pkg::M_ATOM: begin
						if (!word) mode_d = st_mode;
					end
					tlex_pkg::M_QATOM: begin
						if (char_code == tlex_pkg::CH_APOS) mode_d = tlex_pkg::M_IDLE;
					end
					tlex_pkg::M_STR: begin
						if (char_code == tlex_pkg::CH_BSLASH) mode_d = tlex_pkg::M_STRESC;
						else if (char_code == tlex_pkg::CH_DQUOTE) mode_d = tlex_pkg::M_IDLE;
					end
					tlex_pkg::M_STRESC: mode_d = tlex_pkg::M_STR;
					tlex_pkg::M_INT: begin
						if (char_code == tlex_pkg::CH_DOT) mode_d = tlex_pkg::M_DOTWAIT;
						else if (!dig) mode_d = st_mode;
					end
					tlex_pkg::M_DOTWAIT: mode_d = dig ? tlex_pkg::M_FRAC : st_mode;
					tlex_pkg::M_FRAC: begin
						if (!dig) mode_d = st_mode;
					end
					default: mode_d = st_mode;
				endcase
			end
		end
	end

	always_comb begin
		logic [3:0] wk;
		wk = (mode_q == tlex_pkg::M_VAR) ? tlex_pkg::TK_VAR : tlex_pkg::TK_ATOM;
		b = '0;
		if (flush) begin
			case (mode_q)
				tlex_pkg::M_VAR:
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_VAR, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
				tlex_pkg::M_ATOM, tlex_pkg::M_QATOM:
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_ATOM, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
				tlex_pkg::M_INT, tlex_pkg::M_FRAC:
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
				tlex_pkg::M_DOTWAIT: begin
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_DOT, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
				end
				tlex_pkg::M_STR, tlex_pkg::M_STRESC:
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_STR, 1'b0,
						tlex_pkg::CH_NUL, 1'b1));
				default: b = '0;
			endcase
		end else begin
			case (mode_q)
				tlex_pkg::M_VAR, tlex_pkg::M_ATOM: begin
					if (word) begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(wk, 1'b1, char_code, 1'b0));
					end else begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(wk, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
						if (st_has) b = tlex_pkg::add_res(b, st_res);
					end
				end
				tlex_pkg::M_QATOM: begin
					if (char_code == tlex_pkg::CH_APOS)
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_ATOM, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
					else
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_ATOM, 1'b1,
							char_code, 1'b0));
				end
				tlex_pkg::M_STR: begin
					if (char_code == tlex_pkg::CH_DQUOTE)
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_STR, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
					else if (char_code != tlex_pkg::CH_BSLASH)
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_STR, 1'b1,
							char_code, 1'b0));
				end
				tlex_pkg::M_STRESC:
					b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_STR, 1'b1,
						(char_code == tlex_pkg::CH_LOW_N) ? tlex_pkg::CH_NL : char_code,
						1'b0));
				tlex_pkg::M_INT, tlex_pkg::M_FRAC: begin
					if (dig) begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b1,
							char_code, 1'b0));
					end else if (!(mode_q == tlex_pkg::M_INT &&
							char_code == tlex_pkg::CH_DOT)) begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
						if (st_has) b = tlex_pkg::add_res(b, st_res);
					end
				end
				tlex_pkg::M_DOTWAIT: begin
					if (dig) begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b1,
							tlex_pkg::CH_DOT, 1'b0));
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b1,
							char_code, 1'b0));
					end else begin
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_NUM, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
						b = tlex_pkg::add_res(b, tlex_pkg::mk_res(tlex_pkg::TK_DOT, 1'b0,
							tlex_pkg::CH_NUL, 1'b1));
						if (st_has) b = tlex_pkg::add_res(b, st_res);
					end
				end
				default: begin
					if (st_has) b = tlex_pkg::add_res(b, st_res);
				end
			endcase
		end
	end

	assign qwr.push   = acc && (b.count != 2'd0);
	assign qwr.bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tlex_pkg::M_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && flush) |=> (mode_q == tlex_pkg::M_IDLE))
		else $error("lexer not idle after end of text");

	a_esc_from_str: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tlex_pkg::M_STRESC && mode_q != $past(mode_q))
			|-> ($past(mode_q) == tlex_pkg::M_STR))
		else $error("escape state entered outside a string");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.push |-> !q_full)
		else $error("bundle pushed into a full queue");

endmodule

### src/tlex_queue.sv
// Bundle queue between the lexer front end and the result serializer.
// Depends on tlex_pkg.
module tlex_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tlex_pkg::qwr_t     qwr,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output tlex_pkg::bundle_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tlex_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              do_pop;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem_q[wr_ptr_q] <= qwr.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (qwr.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!qwr.push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/tlex_back.sv
// Back end of the term text lexer: walks the head bundle into the output register
// one result per cycle unless stalled, and marks the last result of each byte.
// Depends on tlex_pkg.
module tlex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  tlex_pkg::bundle_t  head,
	input  logic               tok_stall,
	output logic               pop,
	output logic               tok_valid,
	output tlex_pkg::res_t     tok_res,
	output logic               tok_last
);

	logic           valid_q;
	tlex_pkg::res_t res_q;
	logic           last_q;
	logic [1:0]     idx_q;
	logic           load;
	logic           at_last;

	assign load      = !empty && (!valid_q || !tok_stall);
	assign at_last   = (idx_q == (head.count - 2'd1));
	assign pop       = load && at_last;
	assign tok_valid = valid_q;
	assign tok_res   = res_q;
	assign tok_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.res[idx_q];
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (!tok_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < head.count))
		else $error("result index beyond head bundle");

	a_end_or_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.has_char != res_q.token_end))
		else $error("result is neither a body character nor a token end");

	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("result index not rewound after a bundle");

endmodule

### src/term_text_lexer_unit.sv
// Term text lexer: one text byte is taken per cycle while the bundle queue has
// room, and token results leave at one per cycle while tok_stall is low. A byte
// causes 0 to 3 results, so the sustained rate is one byte per cycle only for
// text that averages at most one result per byte; the result serializer sets
// that limit. Results go to the queue as one bundle per byte, then through the
// output register. QUEUE_DEPTH bundles of slack let the two sides stall apart.
module term_text_lexer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic       kind,
	input  logic [7:0] char_code,
	output logic       tok_valid,
	input  logic       tok_stall,
	output logic [3:0] token_kind,
	output logic       has_char,
	output logic [7:0] char_out,
	output logic       token_end,
	output logic       last
);

	tlex_pkg::qwr_t    qwr;
	tlex_pkg::bundle_t head;
	tlex_pkg::res_t    tok_res;
	logic              q_full;
	logic              q_empty;
	logic              pop;

	tlex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.kind       (kind),
		.char_code  (char_code),
		.q_full     (q_full),
		.byte_stall (byte_stall),
		.qwr        (qwr)
	);

	tlex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	tlex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.tok_stall (tok_stall),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_res   (tok_res),
		.tok_last  (last)
	);

	assign token_kind = tok_res.token_kind;
	assign has_char   = tok_res.has_char;
	assign char_out   = tok_res.char_out;
	assign token_end  = tok_res.token_end;

endmodule

### test/tb_term_text_lexer_unit.sv
`timescale 1ns / 100ps
// Testbench for term_text_lexer_unit: streams directed and random term text and
// checks every token result against a lexer predictor kept in this file.
// Depends on tlex_pkg for the state encoding, token kinds and character codes.
module tb_term_text_lexer_unit;

	localparam int CYCLE_LIMIT = 40000;
	localparam int RANDOM_BYTES = 300;

	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
	} text_byte_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic       has_char;
		logic [7:0] char_out;
		logic       token_end;
		logic       last;
	} token_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic       kind = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic       tok_valid;
	logic       tok_stall = 1'b0;
	logic [3:0] token_kind;
	logic       has_char;
	logic [7:0] char_out;
	logic       token_end;
	logic       last;

	text_byte_t        text_queue[$];
	token_rec_t        tokens_due[$];
	token_rec_t        step_buf[tlex_pkg::MAX_RES];
	int                step_cnt;
	tlex_pkg::mode_t   lex_mode = tlex_pkg::M_IDLE;
	int                bytes_taken = 0;
	int                tokens_seen = 0;
	int                bytes_queued = 0;
	int                cycle_count = 0;
	int                reports = 0;
	logic              failed = 1'b0;

	term_text_lexer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.kind(kind),
		.char_code(char_code),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.token_kind(token_kind),
		.has_char(has_char),
		.char_out(char_out),
		.token_end(token_end),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic is_digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_upper_ch(logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic logic is_lower_ch(logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic logic is_word_ch(logic [7:0] c);
		return is_digit_ch(c) || is_upper_ch(c) || is_lower_ch(c) ||
			c == tlex_pkg::CH_USCORE;
	endfunction

	function automatic void put_token(logic [3:0] k, logic has, logic [7:0] ch, logic fin);
		token_rec_t t;
		t.token_kind = k;
		t.has_char = has;
		t.char_out = has ? ch : tlex_pkg::CH_NUL;
		t.token_end = fin;
		t.last = 1'b0;
		if (step_cnt < tlex_pkg::MAX_RES) begin
			step_buf[step_cnt] = t;
			step_cnt++;
		end
	endfunction

	function automatic void put_end(logic [3:0] k);
		put_token(k, 1'b0, tlex_pkg::CH_NUL, 1'b1);
	endfunction

	function automatic void open_token(logic [7:0] c);
		lex_mode = tlex_pkg::M_IDLE;
		case (c)
			tlex_pkg::CH_COMMA: put_end(tlex_pkg::TK_COMMA);
			tlex_pkg::CH_DOT: put_end(tlex_pkg::TK_DOT);
			tlex_pkg::CH_LPAR: put_end(tlex_pkg::TK_LPAR);
			tlex_pkg::CH_RPAR: put_end(tlex_pkg::TK_RPAR);
			tlex_pkg::CH_LBRK: put_end(tlex_pkg::TK_LBRK);
			tlex_pkg::CH_RBRK: put_end(tlex_pkg::TK_RBRK);
			tlex_pkg::CH_LBRC: put_end(tlex_pkg::TK_LBRC);
			tlex_pkg::CH_RBRC: put_end(tlex_pkg::TK_RBRC);
			tlex_pkg::CH_APOS: lex_mode = tlex_pkg::M_QATOM;
			tlex_pkg::CH_DQUOTE: lex_mode = tlex_pkg::M_STR;
			default: begin
				if (is_digit_ch(c)) begin
					put_token(tlex_pkg::TK_NUM, 1'b1, c, 1'b0);
					lex_mode = tlex_pkg::M_INT;
				end else if (is_upper_ch(c)) begin
					put_token(tlex_pkg::TK_VAR, 1'b1, c, 1'b0);
					lex_mode = tlex_pkg::M_VAR;
				end else if (is_lower_ch(c)) begin
					put_token(tlex_pkg::TK_ATOM, 1'b1, c, 1'b0);
					lex_mode = tlex_pkg::M_ATOM;
				end
			end
		endcase
	endfunction

	// Advances the predicted lexer by one accepted request and queues its results.
	function automatic void lex_request(logic is_end, logic [7:0] c);
		token_rec_t t;
		logic [3:0] word_kind;
		step_cnt = 0;
		if (is_end || c == tlex_pkg::CH_NUL) begin
			case (lex_mode)
				tlex_pkg::M_VAR: put_end(tlex_pkg::TK_VAR);
				tlex_pkg::M_ATOM, tlex_pkg::M_QATOM: put_end(tlex_pkg::TK_ATOM);
				tlex_pkg::M_INT, tlex_pkg::M_FRAC: put_end(tlex_pkg::TK_NUM);
				tlex_pkg::M_DOTWAIT: begin
					put_end(tlex_pkg::TK_NUM);
					put_end(tlex_pkg::TK_DOT);
				end
				tlex_pkg::M_STR, tlex_pkg::M_STRESC: put_end(tlex_pkg::TK_STR);
				default: ;
			endcase
			lex_mode = tlex_pkg::M_IDLE;
		end else begin
			case (lex_mode)
				tlex_pkg::M_VAR, tlex_pkg::M_ATOM: begin
					word_kind = (lex_mode == tlex_pkg::M_VAR) ?
						tlex_pkg::TK_VAR : tlex_pkg::TK_ATOM;
					if (is_word_ch(c)) begin
						put_token(word_kind, 1'b1, c, 1'b0);
					end else begin
						put_end(word_kind);
						open_token(c);
					end
				end
				tlex_pkg::M_QATOM: begin
					if (c == tlex_pkg::CH_APOS) begin
						put_end(tlex_pkg::TK_ATOM);
						lex_mode = tlex_pkg::M_IDLE;
					end else begin
						put_token(tlex_pkg::TK_ATOM, 1'b1, c, 1'b0);
					end
				end
				tlex_pkg::M_STR: begin
					if (c == tlex_pkg::CH_BSLASH) begin
						lex_mode = tlex_pkg::M_STRESC;
					end else if (c == tlex_pkg::CH_DQUOTE) begin
						put_end(tlex_pkg::TK_STR);
						lex_mode = tlex_pkg::M_IDLE;
					end else begin
						put_token(tlex_pkg::TK_STR, 1'b1, c, 1'b0);
					end
				end
				tlex_pkg::M_STRESC: begin
					put_token(tlex_pkg::TK_STR, 1'b1,
						(c == tlex_pkg::CH_LOW_N) ? tlex_pkg::CH_NL : c, 1'b0);
					lex_mode = tlex_pkg::M_STR;
				end
				tlex_pkg::M_INT: begin
					if (is_digit_ch(c)) begin
						put_token(tlex_pkg::TK_NUM, 1'b1, c, 1'b0);
					end else if (c == tlex_pkg::CH_DOT) begin
						lex_mode = tlex_pkg::M_DOTWAIT;
					end else begin
						put_end(tlex_pkg::TK_NUM);
						open_token(c);
					end
				end
				tlex_pkg::M_DOTWAIT: begin
					if (is_digit_ch(c)) begin
						put_token(tlex_pkg::TK_NUM, 1'b1, tlex_pkg::CH_DOT, 1'b0);
						put_token(tlex_pkg::TK_NUM, 1'b1, c, 1'b0);
						lex_mode = tlex_pkg::M_FRAC;
					end else begin
						put_end(tlex_pkg::TK_NUM);
						put_end(tlex_pkg::TK_DOT);
						open_token(c);
					end
				end
				tlex_pkg::M_FRAC: begin
					if (is_digit_ch(c)) begin
						put_token(tlex_pkg::TK_NUM, 1'b1, c, 1'b0);
					end else begin
						put_end(tlex_pkg::TK_NUM);
						open_token(c);
					end
				end
				default: open_token(c);
			endcase
		end
		for (int i = 0; i < step_cnt; i++) begin
			t = step_buf[i];
			t.last = (i == step_cnt - 1);
			tokens_due = {tokens_due, t};
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			failed = 1'b1;
			if (reports < 100)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			reports++;
		end
	endtask

	// Request driver: holds each request until it is taken, idles at random.
	always @(posedge clk or negedge arst_n) begin : text_driver
		text_byte_t nxt;
		logic calm;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			kind <= 1'b0;
			char_code <= tlex_pkg::CH_NUL;
		end else begin
			if (byte_valid && !byte_stall) begin
				lex_request(kind, char_code);
				bytes_taken++;
			end
			calm = bytes_taken >= 150 && bytes_taken < 230;
			if (!byte_valid || !byte_stall) begin
				if (text_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
					nxt = text_queue.pop_front();
					byte_valid <= 1'b1;
					kind <= nxt.is_end;
					char_code <= nxt.ch;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Token monitor: compares each taken result with the oldest expected token.
	always @(posedge clk or negedge arst_n) begin : token_monitor
		token_rec_t want;
		logic calm;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tokens_due.size() == 0) begin
					failed = 1'b1;
					if (reports < 100)
						$display("%0t ns: token expected none, got kind %0d char %0d",
							$time, token_kind, char_out);
					reports++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.token_kind, token_kind);
					check_field("has_char", want.has_char, has_char);
					check_field("char_out", want.char_out, char_out);
					check_field("token_end", want.token_end, token_end);
					check_field("last", want.last, last);
				end
				tokens_seen++;
			end
			calm = tokens_seen >= 150 && tokens_seen < 250;
			tok_stall <= !calm && ($urandom_range(0, 99) < 15);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(input logic is_end, input logic [7:0] c);
		text_byte_t b;
		b.is_end = is_end;
		b.ch = c;
		text_queue = {text_queue, b};
		bytes_queued++;
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range(48, 57));
	endfunction

	function automatic logic [7:0] rand_word_ch();
		case ($urandom_range(0, 3))
			0: return rand_digit();
			1: return 8'($urandom_range(65, 90));
			2: return 8'($urandom_range(97, 122));
			default: return tlex_pkg::CH_USCORE;
		endcase
	endfunction

	function automatic logic [7:0] rand_body_ch(logic [7:0] stop);
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		return (c == stop) ? "x" : c;
	endfunction

	task automatic add_random_piece();
		logic [7:0] punct[8];
		punct = '{tlex_pkg::CH_COMMA, tlex_pkg::CH_DOT, tlex_pkg::CH_LPAR,
			tlex_pkg::CH_RPAR, tlex_pkg::CH_LBRK, tlex_pkg::CH_RBRK,
			tlex_pkg::CH_LBRC, tlex_pkg::CH_RBRC};
		case ($urandom_range(0, 11))
			0: begin
				send(1'b0, 8'($urandom_range(65, 90)));
				repeat ($urandom_range(0, 4)) send(1'b0, rand_word_ch());
			end
			1: begin
				send(1'b0, 8'($urandom_range(97, 122)));
				repeat ($urandom_range(0, 4)) send(1'b0, rand_word_ch());
			end
			2: begin
				repeat ($urandom_range(1, 3)) send(1'b0, rand_digit());
				if ($urandom_range(0, 1)) begin
					send(1'b0, tlex_pkg::CH_DOT);
					repeat ($urandom_range(1, 3)) send(1'b0, rand_digit());
				end
			end
			3: begin
				repeat ($urandom_range(1, 2)) send(1'b0, rand_digit());
				send(1'b0, tlex_pkg::CH_DOT);
				case ($urandom_range(0, 3))
					0: send(1'b0, " ");
					1: send(1'b1, 8'($urandom_range(0, 255)));
					2: send(1'b0, 8'($urandom_range(97, 122)));
					default: send(1'b0, punct[$urandom_range(0, 7)]);
				endcase
			end
			4: begin
				send(1'b0, tlex_pkg::CH_APOS);
				repeat ($urandom_range(0, 4)) send(1'b0, rand_body_ch(tlex_pkg::CH_APOS));
				if ($urandom_range(0, 9) != 0)
					send(1'b0, tlex_pkg::CH_APOS);
			end
			5: begin
				send(1'b0, tlex_pkg::CH_DQUOTE);
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 3) == 0) begin
						send(1'b0, tlex_pkg::CH_BSLASH);
						send(1'b0, $urandom_range(0, 1) ? tlex_pkg::CH_LOW_N :
							rand_body_ch(tlex_pkg::CH_NUL));
					end else begin
						send(1'b0, rand_body_ch(tlex_pkg::CH_DQUOTE));
					end
				end
				if ($urandom_range(0, 9) != 0)
					send(1'b0, tlex_pkg::CH_DQUOTE);
			end
			6, 7: send(1'b0, punct[$urandom_range(0, 7)]);
			8: send(1'b0, $urandom_range(0, 1) ? " " : tlex_pkg::CH_NL);
			9: send(1'b0, 8'($urandom_range(0, 255)));
			10: send(1'b1, 8'($urandom_range(0, 255)));
			default: send(1'b0, $urandom_range(0, 1) ? tlex_pkg::CH_USCORE :
				8'($urandom_range(128, 255)));
		endcase
	endtask

	initial begin
		// Empty quoted atom and empty string.
		send(1'b0, tlex_pkg::CH_APOS);
		send(1'b0, tlex_pkg::CH_APOS);
		send(1'b0, tlex_pkg::CH_DQUOTE);
		send(1'b0, tlex_pkg::CH_DQUOTE);
		// String with a newline escape, cut off by end of text with a backslash pending.
		send(1'b0, tlex_pkg::CH_DQUOTE);
		send(1'b0, tlex_pkg::CH_BSLASH);
		send(1'b0, tlex_pkg::CH_LOW_N);
		send(1'b0, tlex_pkg::CH_BSLASH);
		send(1'b1, 8'hFF);
		// A fraction, then a dot that is followed by a non-digit.
		send(1'b0, "1");
		send(1'b0, tlex_pkg::CH_DOT);
		send(1'b0, "2");
		send(1'b0, tlex_pkg::CH_DOT);
		send(1'b0, tlex_pkg::CH_LPAR);
		// A pending dot flushed by a zero byte.
		send(1'b0, "9");
		send(1'b0, tlex_pkg::CH_DOT);
		send(1'b0, tlex_pkg::CH_NUL);
		// Skipped bytes while no token is open, then a variable, an atom and punctuation.
		send(1'b0, tlex_pkg::CH_USCORE);
		send(1'b0, 8'hFF);
		send(1'b0, "A");
		send(1'b0, "b");
		send(1'b0, tlex_pkg::CH_RPAR);
		send(1'b0, "a");
		send(1'b0, tlex_pkg::CH_COMMA);
		send(1'b0, tlex_pkg::CH_LBRK);
		send(1'b0, tlex_pkg::CH_RBRK);
		send(1'b0, tlex_pkg::CH_LBRC);
		send(1'b0, tlex_pkg::CH_RBRC);
		while (bytes_queued < RANDOM_BYTES + 28)
			add_random_piece();
		send(1'b1, tlex_pkg::CH_NUL);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (text_queue.size() > 0 || byte_valid)
			@(posedge clk);
		while (tokens_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed && tokens_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
